>>> rtl/sig_pkg.sv
package sig_pkg;

    // number format
    localparam int FRAC_BITS   = 16;
    localparam int X_W         = 24;
    localparam int Y_W         = 17;
    localparam int OUT_W       = 24;
    localparam int CLAMP_LIMIT = 45;

    // exp(-a) = exp(-a/64)^64: taylor series, reciprocal, then repeated squaring
    localparam int SQUARINGS = 6;
    localparam int TERMS     = 16;
    localparam int G_W       = 32;
    localparam int SUM_W     = G_W + 2;
    localparam int E_W       = 32;
    localparam int D_W       = E_W + 1;
    localparam int G_SHIFT   = G_W - SQUARINGS - FRAC_BITS;

    // clamp compare width
    localparam int XC_W = X_W + 8;
    localparam logic signed [XC_W-1:0] LIM_POS = XC_W'(longint'(CLAMP_LIMIT) << FRAC_BITS);
    localparam logic signed [XC_W-1:0] LIM_NEG = -LIM_POS;

    // final rounding division
    localparam int Q_W   = FRAC_BITS + 1;
    localparam int NUM_W = FRAC_BITS + E_W + 1;

    // gradient path widths
    localparam int BA_W = ((FRAC_BITS > Y_W) ? FRAC_BITS : Y_W) + 1;
    localparam int P1_W = BA_W + Y_W;
    localparam int P2_W = P1_W + X_W;
    localparam int R_W  = P2_W - 2 * FRAC_BITS;
    localparam int RC_W = ((R_W > OUT_W) ? R_W : OUT_W) + 1;
    localparam int FC_W = ((Q_W > OUT_W) ? Q_W : OUT_W) + 1;

    localparam logic [OUT_W-1:0] OUT_MAX = OUT_W'((longint'(1) << (OUT_W - 1)) - 1);
    localparam logic [OUT_W-1:0] OUT_MIN = OUT_W'(longint'(1) << (OUT_W - 1));

    // exact floor(n / k) for n below 2^32: (n * DIV_MUL[k]) >> DIV_SHIFT[k]
    localparam int DIV_SHIFT [2:TERMS] = '{33, 34, 34, 35, 35, 35, 35,
                                           36, 36, 36, 36, 36, 36, 36, 36};
    localparam logic [32:0] DIV_MUL [2:TERMS] = '{
        33'((65'd1 << 33) / 2 + 1),
        33'((65'd1 << 34) / 3 + 1),
        33'((65'd1 << 34) / 4 + 1),
        33'((65'd1 << 35) / 5 + 1),
        33'((65'd1 << 35) / 6 + 1),
        33'((65'd1 << 35) / 7 + 1),
        33'((65'd1 << 35) / 8 + 1),
        33'((65'd1 << 36) / 9 + 1),
        33'((65'd1 << 36) / 10 + 1),
        33'((65'd1 << 36) / 11 + 1),
        33'((65'd1 << 36) / 12 + 1),
        33'((65'd1 << 36) / 13 + 1),
        33'((65'd1 << 36) / 14 + 1),
        33'((65'd1 << 36) / 15 + 1),
        33'((65'd1 << 36) / 16 + 1)
    };

    // pipeline depths
    localparam int SERIES_LAT = 2 * (TERMS - 1) + 1;
    localparam int RECIP_LAT  = E_W;
    localparam int SQUARE_LAT = 2 * SQUARINGS;
    localparam int RATIO_LAT  = Q_W + 1;
    localparam int FWD_LAT    = 1 + SERIES_LAT + RECIP_LAT + SQUARE_LAT + RATIO_LAT;
    localparam int BWD_STAGES = 3;
    localparam int BWD_DLY    = FWD_LAT - BWD_STAGES;

    typedef struct packed {
        logic valid;
        logic mode;
        logic neg;
    } side_t;

endpackage

>>> rtl/sigmoid_activation_fwd_bwd.sv
// Logistic sigmoid, forward and backward, fully pipelined. A beat is taken on every
// cycle that start is high (busy is always low) and its result appears on result_value
// with done high for one cycle once it has passed the forward pipe and the output register,
// in either mode; results are never held, so the receiver must take each one as it comes.
// The depth is set by the forward path: 31 stages of taylor series (a multiply and a
// reciprocal divide per term), 32 stages of one-bit restoring division for the reciprocal,
// 12 stages for six squarings with rounding, and 18 stages for the final rounded ratio.
// The backward product is done in three stages and delayed to line up with it.
module sigmoid_activation_fwd_bwd (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               mode,
    input  logic signed [sig_pkg::X_W-1:0]     x_value,
    input  logic [sig_pkg::Y_W-1:0]            forward_output,
    input  logic signed [sig_pkg::X_W-1:0]     gradient_in,
    output logic                               done,
    output logic signed [sig_pkg::OUT_W-1:0]   result_value
);
    import sig_pkg::*;

    // forward front end
    logic signed [XC_W-1:0] x_ext;
    logic signed [XC_W-1:0] x_clamp;
    logic [X_W-1:0]         a_mag;
    logic [G_W-1:0]         g_next;
    side_t                  side0_next;

    side_t                  side0_reg;
    logic [G_W-1:0]         g0_reg;

    side_t                  series_side;
    logic [SUM_W-1:0]       series_sum;
    side_t                  recip_side;
    logic [E_W-1:0]         recip_e;
    side_t                  square_side;
    logic [E_W-1:0]         square_e;
    side_t                  ratio_side;
    logic [Q_W-1:0]         ratio_q;

    // backward path
    logic signed [BA_W:0]   one_minus_y;
    logic [BA_W-1:0]        ma;
    logic [X_W-1:0]         md;
    logic                   negb;
    logic [P1_W-1:0]        p1_next;
    logic [P2_W-1:0]        p2_next;
    logic [P2_W-1:0]        round_sum;
    logic [R_W-1:0]         round_mag;
    logic [OUT_W-1:0]       bwd_next;

    logic [P1_W-1:0]        p1_reg;
    logic [X_W-1:0]         md_reg;
    logic                   negb1_reg;
    logic [P2_W-1:0]        p2_reg;
    logic                   negb2_reg;
    logic [OUT_W-1:0]       bwd_res_reg;
    logic [OUT_W-1:0]       bwd_dly_reg [BWD_DLY];

    // output stage
    logic [OUT_W-1:0]       fwd_val;
    logic [OUT_W-1:0]       result_next;
    logic                   done_next;
    logic [OUT_W-1:0]       result_reg;
    logic                   done_reg;

    assign busy = 1'b0;

    // clamp, magnitude and scale to a/64 in Q0.32
    assign x_ext   = XC_W'(x_value);
    assign x_clamp = (x_ext > LIM_POS) ? LIM_POS : ((x_ext < LIM_NEG) ? LIM_NEG : x_ext);
    assign a_mag   = x_clamp[XC_W-1] ? X_W'(-x_clamp) : X_W'(x_clamp);
    assign g_next  = G_W'(a_mag) << G_SHIFT;

    always_comb
    begin
        side0_next.valid = start;
        side0_next.mode  = mode;
        side0_next.neg   = x_clamp[XC_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side0_reg <= '0;
        end
        else
        begin
            side0_reg <= side0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g0_reg <= g_next;
    end

    sig_series u_series (
        .clk      (clk),
        .rst_n    (rst_n),
        .side_in  (side0_reg),
        .g_in     (g0_reg),
        .side_out (series_side),
        .sum_out  (series_sum)
    );

    sig_recip u_recip (
        .clk      (clk),
        .rst_n    (rst_n),
        .side_in  (series_side),
        .sum_in   (series_sum),
        .side_out (recip_side),
        .e_out    (recip_e)
    );

    sig_square u_square (
        .clk      (clk),
        .rst_n    (rst_n),
        .side_in  (recip_side),
        .e_in     (recip_e),
        .side_out (square_side),
        .e_out    (square_e)
    );

    sig_ratio u_ratio (
        .clk      (clk),
        .rst_n    (rst_n),
        .side_in  (square_side),
        .e_in     (square_e),
        .side_out (ratio_side),
        .q_out    (ratio_q)
    );

    // (1 - y) * y * dy as sign and magnitude
    assign one_minus_y = $signed((BA_W + 1)'(1) << FRAC_BITS)
                         - $signed((BA_W + 1)'(forward_output));
    assign ma      = one_minus_y[BA_W] ? BA_W'(-one_minus_y) : BA_W'(one_minus_y);
    assign md      = gradient_in[X_W-1] ? X_W'(-gradient_in) : X_W'(gradient_in);
    assign negb    = one_minus_y[BA_W] ^ gradient_in[X_W-1];
    assign p1_next = P1_W'(ma) * P1_W'(forward_output);
    assign p2_next = P2_W'(p1_reg) * P2_W'(md_reg);

    // round half away from zero on the magnitude, then saturate
    assign round_sum = p2_reg + (P2_W'(1) << (2 * FRAC_BITS - 1));
    assign round_mag = R_W'(round_sum >> (2 * FRAC_BITS));

    always_comb
    begin
        if (negb2_reg)
        begin
            if (RC_W'(round_mag) > RC_W'(OUT_MIN))
                bwd_next = OUT_MIN;
            else
                bwd_next = OUT_W'(RC_W'(0) - RC_W'(round_mag));
        end
        else
        begin
            if (RC_W'(round_mag) > RC_W'(OUT_MAX))
                bwd_next = OUT_MAX;
            else
                bwd_next = OUT_W'(round_mag);
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg         <= p1_next;
        md_reg         <= md;
        negb1_reg      <= negb;
        p2_reg         <= p2_next;
        negb2_reg      <= negb1_reg;
        bwd_res_reg    <= bwd_next;
        bwd_dly_reg[0] <= bwd_res_reg;
        for (int i = 1; i < BWD_DLY; i++)
        begin
            bwd_dly_reg[i] <= bwd_dly_reg[i-1];
        end
    end

    // pick the beat's result at the end of the forward pipe
    assign fwd_val     = (FC_W'(ratio_q) > FC_W'(OUT_MAX)) ? OUT_MAX : OUT_W'(ratio_q);
    assign result_next = ratio_side.mode ? bwd_dly_reg[BWD_DLY-1] : fwd_val;
    assign done_next   = ratio_side.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done         = done_reg;
    assign result_value = result_reg;

endmodule

>>> rtl/sig_series.sv
module sig_series (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sig_pkg::side_t             side_in,
    input  logic [sig_pkg::G_W-1:0]    g_in,
    output sig_pkg::side_t             side_out,
    output logic [sig_pkg::SUM_W-1:0]  sum_out
);
    import sig_pkg::*;

    localparam int PA_W = 2 * G_W;
    localparam int PB_W = G_W + 33;

    side_t            a_side_reg [2:TERMS];
    logic [G_W-1:0]   a_g_reg    [2:TERMS];
    logic [G_W-1:0]   a_p_reg    [2:TERMS];
    logic [SUM_W-1:0] a_sum_reg  [2:TERMS];
    side_t            b_side_reg [2:TERMS];
    logic [G_W-1:0]   b_g_reg    [2:TERMS];
    logic [G_W-1:0]   b_term_reg [2:TERMS];
    logic [SUM_W-1:0] b_sum_reg  [2:TERMS];

    side_t            side_out_reg;
    logic [SUM_W-1:0] sum_out_reg;

    generate
        for (genvar k = 2; k <= TERMS; k++)
        begin : g_term
            side_t            side_src;
            logic [G_W-1:0]   g_src;
            logic [G_W-1:0]   term_src;
            logic [SUM_W-1:0] sum_src;
            logic [PA_W-1:0]  prod_a;
            logic [PB_W-1:0]  prod_b;
            logic [G_W-1:0]   p_next;
            logic [G_W-1:0]   term_next;
            logic [SUM_W-1:0] sum_next;

            if (k == 2)
            begin : g_head
                // term one is g itself, sum starts at one
                assign side_src = side_in;
                assign g_src    = g_in;
                assign term_src = g_in;
                assign sum_src  = SUM_W'(1) << G_W;
            end
            else
            begin : g_body
                assign side_src = b_side_reg[k-1];
                assign g_src    = b_g_reg[k-1];
                assign term_src = b_term_reg[k-1];
                assign sum_src  = b_sum_reg[k-1];
            end

            assign prod_a    = PA_W'(term_src) * PA_W'(g_src);
            assign p_next    = prod_a[PA_W-1:G_W];
            assign sum_next  = sum_src + SUM_W'(term_src);
            // divide by k through the reciprocal
            assign prod_b    = PB_W'(a_p_reg[k]) * PB_W'(DIV_MUL[k]);
            assign term_next = G_W'(prod_b >> DIV_SHIFT[k]);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    a_side_reg[k] <= '0;
                    b_side_reg[k] <= '0;
                end
                else
                begin
                    a_side_reg[k] <= side_src;
                    b_side_reg[k] <= a_side_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                a_g_reg[k]    <= g_src;
                a_p_reg[k]    <= p_next;
                a_sum_reg[k]  <= sum_next;
                b_g_reg[k]    <= a_g_reg[k];
                b_term_reg[k] <= term_next;
                b_sum_reg[k]  <= a_sum_reg[k];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_out_reg <= '0;
        end
        else
        begin
            side_out_reg <= b_side_reg[TERMS];
        end
    end

    always_ff @(posedge clk)
    begin
        sum_out_reg <= b_sum_reg[TERMS] + SUM_W'(b_term_reg[TERMS]);
    end

    assign side_out = side_out_reg;
    assign sum_out  = sum_out_reg;

endmodule

>>> rtl/sig_recip.sv
module sig_recip (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sig_pkg::side_t             side_in,
    input  logic [sig_pkg::SUM_W-1:0]  sum_in,
    output sig_pkg::side_t             side_out,
    output logic [sig_pkg::E_W-1:0]    e_out
);
    import sig_pkg::*;

    side_t            side_reg [E_W];
    logic [SUM_W-1:0] r_reg    [E_W];
    logic [SUM_W-1:0] s_reg    [E_W];
    logic [E_W-1:0]   q_reg    [E_W];

    generate
        for (genvar i = 0; i < E_W; i++)
        begin : g_bit
            side_t            side_src;
            logic [SUM_W-1:0] r_src;
            logic [SUM_W-1:0] s_src;
            logic [E_W-1:0]   q_src;
            logic [SUM_W:0]   trial;
            logic             fit;
            logic [SUM_W-1:0] r_next;
            logic [E_W-1:0]   q_next;

            if (i == 0)
            begin : g_head
                // upper half of the all-ones dividend, already below the divisor
                assign side_src = side_in;
                assign r_src    = SUM_W'((SUM_W'(1) << G_W) - SUM_W'(1));
                assign s_src    = sum_in;
                assign q_src    = '0;
            end
            else
            begin : g_body
                assign side_src = side_reg[i-1];
                assign r_src    = r_reg[i-1];
                assign s_src    = s_reg[i-1];
                assign q_src    = q_reg[i-1];
            end

            // next dividend bit is always one
            assign trial  = {r_src, 1'b1};
            assign fit    = trial >= {1'b0, s_src};
            assign r_next = fit ? SUM_W'(trial - {1'b0, s_src}) : SUM_W'(trial);
            assign q_next = {q_src[E_W-2:0], fit};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    side_reg[i] <= '0;
                end
                else
                begin
                    side_reg[i] <= side_src;
                end
            end

            always_ff @(posedge clk)
            begin
                r_reg[i] <= r_next;
                s_reg[i] <= s_src;
                q_reg[i] <= q_next;
            end
        end
    endgenerate

    assign side_out = side_reg[E_W-1];
    assign e_out    = q_reg[E_W-1];

endmodule

>>> rtl/sig_square.sv
module sig_square (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sig_pkg::side_t           side_in,
    input  logic [sig_pkg::E_W-1:0]  e_in,
    output sig_pkg::side_t           side_out,
    output logic [sig_pkg::E_W-1:0]  e_out
);
    import sig_pkg::*;

    localparam int PR_W = 2 * E_W;

    side_t          m_side_reg [SQUARINGS];
    logic [E_W:0]   m_reg      [SQUARINGS];
    side_t          e_side_reg [SQUARINGS];
    logic [E_W-1:0] e_reg      [SQUARINGS];

    generate
        for (genvar j = 0; j < SQUARINGS; j++)
        begin : g_sq
            side_t           side_src;
            logic [E_W-1:0]  e_src;
            logic [PR_W-1:0] prod;
            logic [E_W-1:0]  e_next;

            if (j == 0)
            begin : g_head
                assign side_src = side_in;
                assign e_src    = e_in;
            end
            else
            begin : g_body
                assign side_src = e_side_reg[j-1];
                assign e_src    = e_reg[j-1];
            end

            assign prod = PR_W'(e_src) * PR_W'(e_src);
            // round to nearest on the dropped half
            assign e_next = m_reg[j][E_W:1] + E_W'(m_reg[j][0]);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    m_side_reg[j] <= '0;
                    e_side_reg[j] <= '0;
                end
                else
                begin
                    m_side_reg[j] <= side_src;
                    e_side_reg[j] <= m_side_reg[j];
                end
            end

            always_ff @(posedge clk)
            begin
                m_reg[j] <= prod[PR_W-1:E_W-1];
                e_reg[j] <= e_next;
            end
        end
    endgenerate

    assign side_out = e_side_reg[SQUARINGS-1];
    assign e_out    = e_reg[SQUARINGS-1];

endmodule

>>> rtl/sig_ratio.sv
module sig_ratio (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sig_pkg::side_t           side_in,
    input  logic [sig_pkg::E_W-1:0]  e_in,
    output sig_pkg::side_t           side_out,
    output logic [sig_pkg::Q_W-1:0]  q_out
);
    import sig_pkg::*;

    localparam int HI_W = NUM_W - Q_W;

    logic [NUM_W-1:0] half;
    logic [NUM_W-1:0] num_next;
    logic [D_W-1:0]   d_next;

    side_t            p_side_reg;
    logic [D_W-1:0]   p_d_reg;
    logic [D_W-1:0]   p_r_reg;
    logic [Q_W-1:0]   p_lo_reg;

    side_t            side_reg [Q_W];
    logic [D_W-1:0]   d_reg    [Q_W];
    logic [D_W-1:0]   r_reg    [Q_W];
    logic [Q_W-1:0]   lo_reg   [Q_W];
    logic [Q_W-1:0]   q_reg    [Q_W];

    // d = 1 + e, and d/2 = 2^31 + e/2 with no carry
    assign d_next = D_W'(e_in) + (D_W'(1) << E_W);
    assign half   = NUM_W'({1'b1, e_in[E_W-1:1]});
    assign num_next = side_in.neg ? (NUM_W'(e_in) << FRAC_BITS) + half
                                  : (NUM_W'(1) << (FRAC_BITS + E_W)) + half;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_side_reg <= '0;
        end
        else
        begin
            p_side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        p_d_reg  <= d_next;
        p_r_reg  <= D_W'(num_next[NUM_W-1:NUM_W-HI_W]);
        p_lo_reg <= num_next[Q_W-1:0];
    end

    generate
        for (genvar i = 0; i < Q_W; i++)
        begin : g_bit
            side_t          side_src;
            logic [D_W-1:0] d_src;
            logic [D_W-1:0] r_src;
            logic [Q_W-1:0] lo_src;
            logic [Q_W-1:0] q_src;
            logic [D_W:0]   trial;
            logic           fit;
            logic [D_W-1:0] r_next;

            if (i == 0)
            begin : g_head
                assign side_src = p_side_reg;
                assign d_src    = p_d_reg;
                assign r_src    = p_r_reg;
                assign lo_src   = p_lo_reg;
                assign q_src    = '0;
            end
            else
            begin : g_body
                assign side_src = side_reg[i-1];
                assign d_src    = d_reg[i-1];
                assign r_src    = r_reg[i-1];
                assign lo_src   = lo_reg[i-1];
                assign q_src    = q_reg[i-1];
            end

            assign trial  = {r_src, lo_src[Q_W-1]};
            assign fit    = trial >= {1'b0, d_src};
            assign r_next = fit ? D_W'(trial - {1'b0, d_src}) : D_W'(trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    side_reg[i] <= '0;
                end
                else
                begin
                    side_reg[i] <= side_src;
                end
            end

            always_ff @(posedge clk)
            begin
                d_reg[i]  <= d_src;
                r_reg[i]  <= r_next;
                lo_reg[i] <= lo_src << 1;
                q_reg[i]  <= {q_src[Q_W-2:0], fit};
            end
        end
    endgenerate

    assign side_out = side_reg[Q_W-1];
    assign q_out    = q_reg[Q_W-1];

endmodule
